>>> design/c8alu_pkg.sv
// shared types, codes and constants for the block-3 alu and restart unit
`timescale 1ns / 1ps

package c8alu_pkg;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // beat widths
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 80;

    // opcode group codes, opcode bits 2..0
    localparam logic [2:0] GRP_ALU = 3'b110;
    localparam logic [2:0] GRP_RST = 3'b111;

    // cycle costs
    localparam logic [4:0] COST_NONE = 5'd0;
    localparam logic [4:0] COST_ALU  = 5'd8;
    localparam logic [4:0] COST_RST  = 5'd16;

    // alu operation, opcode bits 5..3
    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_ADC = 3'd1,
        OP_SUB = 3'd2,
        OP_SBC = 3'd3,
        OP_AND = 3'd4,
        OP_XOR = 3'd5,
        OP_OR  = 3'd6,
        OP_CP  = 3'd7
    } alu_op_t;

    // instruction class decided by the front
    typedef enum logic [1:0] {
        KIND_NOP = 2'd0,
        KIND_ALU = 2'd1,
        KIND_RST = 2'd2
    } kind_t;

    // queue entry: final register values plus the return address
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  acc;
        logic [7:0]  flags;
        logic [15:0] pc;
        logic [15:0] sp;
        logic [15:0] ret;
    } entry_t;

    // queue status seen by front and back
    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    // one result beat
    typedef struct packed {
        logic [7:0]  acc;
        logic [7:0]  flags;
        logic [15:0] pc;
        logic [15:0] sp;
        logic        mem_write;
        logic [15:0] waddr;
        logic [7:0]  wdata;
        logic [4:0]  cost;
        logic        last;
    } beat_t;

endpackage

>>> design/cpu8_alu_immediate_and_restart.sv
// top level of the block-3 immediate alu and restart unit
//
// channel   dir  width  content
// s_*       in   64     instruction beat: opcode, immediate, a, f, pc, sp
// m_*       out  80+1   result beat: a, f, pc, sp, stack write, cost; tlast ends instruction
//
// one instruction is accepted per cycle while the queue has room; an alu or
// no-op instruction gives one beat, a restart gives two beats, the second
// straight after the first is taken, so the output port sets the rate.
// an accepted instruction is written into the queue at the accepting edge and
// reaches the output register once that is free and the entries ahead of it
// have gone. reset clears the queue and the output register; a stalled output
// only stops the front once the queue is full.
`timescale 1ns / 1ps

module cpu8_alu_immediate_and_restart
#(
    parameter int QUEUE_DEPTH = c8alu_pkg::QUEUE_DEPTH
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // opcode[7:0], immediate[15:8], acc_in[23:16], flags_in[31:24],
    // pc_in[47:32], sp_in[63:48]
    input  logic [c8alu_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // acc_out[7:0], flags_out[15:8], pc_out[31:16], sp_out[47:32],
    // write_address[63:48], write_data[71:64], cycle_cost[76:72], zero pad
    output logic [c8alu_pkg::OUT_DATA_W-1:0] m_tdata,
    // mem_write[0]
    output logic                             m_tuser,
    output logic                             m_tlast
);

    c8alu_pkg::q_status_t q_status;
    c8alu_pkg::entry_t    wr_entry;
    c8alu_pkg::entry_t    rd_entry;
    logic                 push;
    logic                 pop;

    // decode and alu
    c8alu_front u_front
    (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_status (q_status),
        .push     (push),
        .entry    (wr_entry)
    );

    // decoupling queue
    c8alu_fifo
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .pop      (pop),
        .rd_entry (rd_entry),
        .status   (q_status)
    );

    // result sequencing
    c8alu_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_entry  (rd_entry),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // only the first restart beat is not last, and it carries a write
    a_first_beat_writes : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tuser && (m_tdata[76:72] == c8alu_pkg::COST_NONE))
        else $error("non-last beat without stack write or with a cost");

    // the second restart beat follows straight after the first is taken
    a_second_beat_next : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tlast && m_tuser)
        else $error("second restart beat missing");

    // second restart beat writes one below the first and charges the restart cost
    a_second_beat_addr : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=>
        (m_tdata[63:48] == $past(m_tdata[63:48]) - 16'd1) &&
        (m_tdata[76:72] == c8alu_pkg::COST_RST))
        else $error("second restart beat address or cost wrong");

    // queue never takes a beat while full
    a_no_push_full : assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> !push)
        else $error("push into full queue");

endmodule

>>> design/c8alu_front.sv
// front: accepts instruction beats, classifies them and works out the alu result
`timescale 1ns / 1ps

module c8alu_front
(
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // opcode[7:0], immediate[15:8], acc_in[23:16], flags_in[31:24],
    // pc_in[47:32], sp_in[63:48]
    input  logic [c8alu_pkg::IN_DATA_W-1:0] s_tdata,
    input  c8alu_pkg::q_status_t           q_status,
    output logic                           push,
    output c8alu_pkg::entry_t              entry
);

    logic [7:0]          opcode;
    logic [7:0]          imm;
    logic [7:0]          acc;
    logic [7:0]          flg;
    logic [15:0]         pc;
    logic [15:0]         sp;
    logic                cin;
    logic                cin_op;
    logic [8:0]          sum;
    logic [4:0]          sum_lo;
    logic [8:0]          diff;
    logic [4:0]          diff_lo;
    logic [7:0]          res;
    logic [7:0]          res_flags;
    c8alu_pkg::alu_op_t  op;

    // field split
    assign opcode = s_tdata[7:0];
    assign imm    = s_tdata[15:8];
    assign acc    = s_tdata[23:16];
    assign flg    = s_tdata[31:24];
    assign pc     = s_tdata[47:32];
    assign sp     = s_tdata[63:48];
    assign cin    = flg[4];
    assign op     = c8alu_pkg::alu_op_t'(opcode[5:3]);

    // handshake, queue takes the beat when it has room
    assign s_tready = !q_status.full;
    assign push     = s_tvalid && !q_status.full;

    // carry in only for adc and sbc
    assign cin_op = ((op == c8alu_pkg::OP_ADC) || (op == c8alu_pkg::OP_SBC)) ? cin : 1'b0;

    // shared adder and subtractor with nibble carries
    assign sum     = {1'b0, acc} + {1'b0, imm} + {8'd0, cin_op};
    assign sum_lo  = {1'b0, acc[3:0]} + {1'b0, imm[3:0]} + {4'd0, cin_op};
    assign diff    = {1'b0, acc} - {1'b0, imm} - {8'd0, cin_op};
    assign diff_lo = {1'b0, acc[3:0]} - {1'b0, imm[3:0]} - {4'd0, cin_op};

    // alu result and flags
    always_comb
    begin
        res       = acc;
        res_flags = flg;
        unique case (op)
            c8alu_pkg::OP_ADD, c8alu_pkg::OP_ADC:
            begin
                res       = sum[7:0];
                res_flags = {(sum[7:0] == 8'd0), 1'b0, sum_lo[4], sum[8], flg[3:0]};
            end
            c8alu_pkg::OP_SUB, c8alu_pkg::OP_SBC:
            begin
                res       = diff[7:0];
                res_flags = {(diff[7:0] == 8'd0), 1'b1, diff_lo[4], diff[8], flg[3:0]};
            end
            c8alu_pkg::OP_AND:
            begin
                res       = acc & imm;
                res_flags = {((acc & imm) == 8'd0), 1'b0, 1'b1, 1'b0, 4'd0};
            end
            c8alu_pkg::OP_XOR:
            begin
                res       = acc ^ imm;
                res_flags = {((acc ^ imm) == 8'd0), 3'd0, 4'd0};
            end
            c8alu_pkg::OP_OR:
            begin
                res       = acc | imm;
                res_flags = {((acc | imm) == 8'd0), 3'd0, 4'd0};
            end
            c8alu_pkg::OP_CP:
            begin
                res       = acc;
                res_flags = {(diff[7:0] == 8'd0), 1'b1, diff_lo[4], diff[8], 4'd0};
            end
            default:
            begin
                res       = acc;
                res_flags = flg;
            end
        endcase
    end

    // classify by group and build the queue entry
    always_comb
    begin
        entry.acc   = acc;
        entry.flags = flg;
        entry.pc    = pc;
        entry.sp    = sp;
        entry.ret   = pc + 16'd1;
        entry.kind  = c8alu_pkg::KIND_NOP;
        unique case (opcode[2:0])
            c8alu_pkg::GRP_ALU:
            begin
                entry.kind  = c8alu_pkg::KIND_ALU;
                entry.acc   = res;
                entry.flags = res_flags;
                entry.pc    = pc + 16'd2;
            end
            c8alu_pkg::GRP_RST:
            begin
                entry.kind = c8alu_pkg::KIND_RST;
                entry.pc   = {10'd0, opcode[5:3], 3'd0};
                entry.sp   = sp - 16'd2;
            end
            default:
            begin
                entry.kind = c8alu_pkg::KIND_NOP;
            end
        endcase
    end

endmodule

>>> design/c8alu_fifo.sv
// short queue of decoded instructions between front and back
`timescale 1ns / 1ps

module c8alu_fifo
#(
    parameter int DEPTH = c8alu_pkg::QUEUE_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  c8alu_pkg::entry_t    wr_entry,
    input  logic                 pop,
    output c8alu_pkg::entry_t    rd_entry,
    output c8alu_pkg::q_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    c8alu_pkg::entry_t mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign rd_entry     = mem_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

>>> design/c8alu_back.sv
// back: turns queue entries into result beats, two beats for a restart
`timescale 1ns / 1ps

module c8alu_back
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  c8alu_pkg::entry_t                q_entry,
    input  c8alu_pkg::q_status_t             q_status,
    output logic                             pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // acc_out[7:0], flags_out[15:8], pc_out[31:16], sp_out[47:32],
    // write_address[63:48], write_data[71:64], cycle_cost[76:72], zero pad
    output logic [c8alu_pkg::OUT_DATA_W-1:0] m_tdata,
    // mem_write[0]
    output logic                             m_tuser,
    output logic                             m_tlast
);

    logic              valid_reg;
    logic              valid_next;
    logic              pend_reg;
    logic              pend_next;
    c8alu_pkg::beat_t  beat_reg;
    c8alu_pkg::beat_t  beat_next;
    c8alu_pkg::entry_t hold_reg;
    c8alu_pkg::entry_t hold_next;
    logic              load;

    // output register is free when empty or being taken
    assign load = !valid_reg || m_tready;
    assign pop  = load && !pend_reg && !q_status.empty;

    // beat selection
    always_comb
    begin
        valid_next = valid_reg;
        pend_next  = pend_reg;
        beat_next  = beat_reg;
        hold_next  = hold_reg;
        if (load)
        begin
            if (pend_reg)
            begin
                // second restart beat: low return byte at sp - 2
                valid_next          = 1'b1;
                pend_next           = 1'b0;
                beat_next.acc       = hold_reg.acc;
                beat_next.flags     = hold_reg.flags;
                beat_next.pc        = hold_reg.pc;
                beat_next.sp        = hold_reg.sp;
                beat_next.mem_write = 1'b1;
                beat_next.waddr     = hold_reg.sp;
                beat_next.wdata     = hold_reg.ret[7:0];
                beat_next.cost      = c8alu_pkg::COST_RST;
                beat_next.last      = 1'b1;
            end
            else if (!q_status.empty)
            begin
                valid_next          = 1'b1;
                beat_next.acc       = q_entry.acc;
                beat_next.flags     = q_entry.flags;
                beat_next.pc        = q_entry.pc;
                beat_next.sp        = q_entry.sp;
                beat_next.mem_write = 1'b0;
                beat_next.waddr     = 16'd0;
                beat_next.wdata     = 8'd0;
                beat_next.cost      = c8alu_pkg::COST_NONE;
                beat_next.last      = 1'b1;
                case (q_entry.kind)
                    c8alu_pkg::KIND_ALU:
                    begin
                        beat_next.cost = c8alu_pkg::COST_ALU;
                    end
                    c8alu_pkg::KIND_RST:
                    begin
                        // first restart beat: high return byte at sp - 1
                        beat_next.mem_write = 1'b1;
                        beat_next.waddr     = q_entry.sp + 16'd1;
                        beat_next.wdata     = q_entry.ret[15:8];
                        beat_next.last      = 1'b0;
                        pend_next           = 1'b1;
                        hold_next           = q_entry;
                    end
                    default:
                    begin
                        beat_next.cost = c8alu_pkg::COST_NONE;
                    end
                endcase
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
        hold_reg <= hold_next;
    end

    // port packing
    assign m_tvalid = valid_reg;
    assign m_tuser  = beat_reg.mem_write;
    assign m_tlast  = beat_reg.last;
    assign m_tdata  = {3'd0, beat_reg.cost, beat_reg.wdata, beat_reg.waddr,
                       beat_reg.sp, beat_reg.pc, beat_reg.flags, beat_reg.acc};

endmodule

>>> tb/testbench.sv
// self-checking testbench for the block-3 immediate alu and restart unit
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int RX_HOLD_CYCLES = 64;
    localparam int RANDOM_ITEMS   = 1200;
    localparam int DRAIN_CYCLES   = 8;

    // one expected result beat, fields in the order of the model
    typedef struct packed {
        logic [7:0]  acc;
        logic [7:0]  flags;
        logic [15:0] pc;
        logic [15:0] sp;
        logic        mem_write;
        logic [15:0] waddr;
        logic [7:0]  wdata;
        logic [4:0]  cost;
        logic        last;
    } result_beat_t;

    // directed stimulus row; typed rows carry their single result
    typedef struct {
        logic [7:0]   opc;
        logic [7:0]   imm;
        logic [7:0]   a;
        logic [7:0]   f;
        logic [15:0]  pc;
        logic [15:0]  sp;
        bit           typed;
        result_beat_t want;
    } instr_vec_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [c8alu_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [c8alu_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                             m_tuser;
    logic                             m_tlast;

    result_beat_t expected_beats [$];
    result_beat_t offer_lead;
    result_beat_t offer_tail;
    int           offer_count = 0;
    int           mismatch_count = 0;
    int           cycle_count = 0;
    int           tx_idle_pct = 0;
    int           rx_idle_pct = 0;
    bit           rx_hold_req = 1'b0;

    // opcode, immediate, a, f, pc, sp, typed, expected result
    instr_vec_t directed_vecs [25] = '{
        '{8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b1,
          '{8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, 16'h0, 8'h0,
            c8alu_pkg::COST_NONE, 1'b1}},
        '{8'hFD, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1,
          '{8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0, 16'h0, 8'h0,
            c8alu_pkg::COST_NONE, 1'b1}},
        '{8'hC6, 8'h01, 8'h0F, 8'h00, 16'h0100, 16'hFFFE, 1'b0, '0},
        '{8'hC6, 8'h01, 8'hFF, 8'h0F, 16'hFFFF, 16'h1234, 1'b0, '0},
        '{8'hCE, 8'h00, 8'hFF, 8'h10, 16'h2000, 16'h8000, 1'b0, '0},
        '{8'hCE, 8'h01, 8'h0E, 8'h10, 16'h2002, 16'h8000, 1'b0, '0},
        '{8'hD6, 8'h01, 8'h10, 8'h00, 16'h3000, 16'h0001, 1'b0, '0},
        '{8'hD6, 8'hFF, 8'h00, 8'hFF, 16'hFFFE, 16'h0000, 1'b0, '0},
        '{8'hDE, 8'hFF, 8'h00, 8'h10, 16'h4000, 16'h4000, 1'b0, '0},
        '{8'hDE, 8'h0F, 8'h10, 8'h10, 16'h4002, 16'h4000, 1'b0, '0},
        '{8'hE6, 8'h0F, 8'hF0, 8'hFF, 16'h0100, 16'hFFFE, 1'b1,
          '{8'h00, 8'hA0, 16'h0102, 16'hFFFE, 1'b0, 16'h0, 8'h0,
            c8alu_pkg::COST_ALU, 1'b1}},
        '{8'hE6, 8'hFF, 8'hFF, 8'h00, 16'h5000, 16'h5000, 1'b0, '0},
        '{8'hEE, 8'h5A, 8'h5A, 8'hFF, 16'h0200, 16'h0000, 1'b1,
          '{8'h00, 8'h80, 16'h0202, 16'h0000, 1'b0, 16'h0, 8'h0,
            c8alu_pkg::COST_ALU, 1'b1}},
        '{8'hF6, 8'h00, 8'h00, 8'h0F, 16'h0300, 16'h7FFF, 1'b1,
          '{8'h00, 8'h80, 16'h0302, 16'h7FFF, 1'b0, 16'h0, 8'h0,
            c8alu_pkg::COST_ALU, 1'b1}},
        '{8'hF6, 8'h5A, 8'hA5, 8'h00, 16'h6000, 16'h6000, 1'b0, '0},
        '{8'hFE, 8'h42, 8'h42, 8'h0F, 16'h7000, 16'h7000, 1'b0, '0},
        '{8'hFE, 8'h01, 8'h00, 8'h00, 16'hFFFF, 16'hFFFF, 1'b0, '0},
        '{8'hC7, 8'h00, 8'h12, 8'h34, 16'h0000, 16'h0000, 1'b0, '0},
        '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'h0001, 1'b0, '0},
        '{8'hD7, 8'h55, 8'hAA, 8'h50, 16'h1234, 16'hFFFE, 1'b0, '0},
        '{8'h06, 8'h80, 8'h80, 8'h00, 16'h0400, 16'h0400, 1'b0, '0},
        '{8'h3F, 8'h00, 8'h00, 8'h00, 16'h0500, 16'h0500, 1'b0, '0},
        '{8'h47, 8'h00, 8'h00, 8'h00, 16'h0600, 16'h0600, 1'b0, '0},
        '{8'h86, 8'h01, 8'h7F, 8'h00, 16'h0700, 16'h0700, 1'b0, '0},
        '{8'hC3, 8'h12, 8'h34, 8'h56, 16'h789A, 16'hBCDE, 1'b0, '0}
    };

    cpu8_alu_immediate_and_restart dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #6 clk = ~clk;

    // executes one instruction, returns how many result beats it gives
    function automatic int exec_instr(input logic [7:0] opc, input logic [7:0] imm,
                                      input logic [7:0] a, input logic [7:0] f,
                                      input logic [15:0] pc, input logic [15:0] sp,
                                      output result_beat_t lead,
                                      output result_beat_t tail);
        int          ai;
        int          ni;
        int          ci;
        int          r;
        logic        z;
        logic        n;
        logic        h;
        logic        c;
        logic [3:0]  low_keep;
        logic [15:0] ret;
        ai = a;
        ni = imm;
        ci = f[4];
        lead = '0;
        tail = '0;
        lead.acc = a;
        lead.flags = f;
        lead.pc = pc;
        lead.sp = sp;
        lead.cost = c8alu_pkg::COST_NONE;
        lead.last = 1'b1;
        if (opc[2:0] == c8alu_pkg::GRP_ALU)
        begin
            low_keep = f[3:0];
            case (c8alu_pkg::alu_op_t'(opc[5:3]))
                c8alu_pkg::OP_ADD:
                begin
                    r = ai + ni;
                    z = ((r & 255) == 0);
                    n = 1'b0;
                    h = ((ai & 15) + (ni & 15)) > 15;
                    c = r > 255;
                end
                c8alu_pkg::OP_ADC:
                begin
                    r = ai + ni + ci;
                    z = ((r & 255) == 0);
                    n = 1'b0;
                    h = ((ai & 15) + (ni & 15) + ci) > 15;
                    c = r > 255;
                end
                c8alu_pkg::OP_SUB:
                begin
                    r = ai - ni;
                    z = ((r & 255) == 0);
                    n = 1'b1;
                    h = (ai & 15) < (ni & 15);
                    c = ai < ni;
                end
                c8alu_pkg::OP_SBC:
                begin
                    r = ai - ni - ci;
                    z = ((r & 255) == 0);
                    n = 1'b1;
                    h = (ai & 15) < ((ni & 15) + ci);
                    c = ai < (ni + ci);
                end
                c8alu_pkg::OP_AND:
                begin
                    r = ai & ni;
                    {z, n, h, c} = {r == 0, 1'b0, 1'b1, 1'b0};
                    low_keep = 4'h0;
                end
                c8alu_pkg::OP_XOR:
                begin
                    r = ai ^ ni;
                    {z, n, h, c} = {r == 0, 3'b000};
                    low_keep = 4'h0;
                end
                c8alu_pkg::OP_OR:
                begin
                    r = ai | ni;
                    {z, n, h, c} = {r == 0, 3'b000};
                    low_keep = 4'h0;
                end
                default:
                begin
                    // compare: subtract flags, accumulator kept
                    r = ai;
                    z = (ai == ni);
                    n = 1'b1;
                    h = (ai & 15) < (ni & 15);
                    c = ai < ni;
                    low_keep = 4'h0;
                end
            endcase
            lead.acc = 8'(r);
            lead.flags = {z, n, h, c, low_keep};
            lead.pc = pc + 16'd2;
            lead.cost = c8alu_pkg::COST_ALU;
            return 1;
        end
        if (opc[2:0] == c8alu_pkg::GRP_RST)
        begin
            // push return address high byte first, jump to the restart vector
            ret = pc + 16'd1;
            lead.pc = {10'd0, opc[5:3], 3'd0};
            lead.sp = sp - 16'd2;
            lead.mem_write = 1'b1;
            lead.waddr = sp - 16'd1;
            lead.wdata = ret[15:8];
            lead.last = 1'b0;
            tail = lead;
            tail.waddr = sp - 16'd2;
            tail.wdata = ret[7:0];
            tail.cost = c8alu_pkg::COST_RST;
            tail.last = 1'b1;
            return 2;
        end
        return 1;
    endfunction

    // byte biased towards the corners of the nibble arithmetic
    function automatic logic [7:0] corner_byte();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h0F;
            3: return 8'hF0;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // offers one instruction beat and waits until it is taken
    task automatic offer_instr(input logic [7:0] opc, input logic [7:0] imm,
                               input logic [7:0] a, input logic [7:0] f,
                               input logic [15:0] pc, input logic [15:0] sp,
                               input bit typed, input result_beat_t want);
        result_beat_t lead;
        result_beat_t tail;
        int           count;
        count = exec_instr(opc, imm, a, f, pc, sp, lead, tail);
        if (typed)
        begin
            lead = want;
            count = 1;
        end
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        offer_lead = lead;
        offer_tail = tail;
        offer_count = count;
        s_tvalid <= 1'b1;
        s_tdata <= {sp, pc, f, a, imm, opc};
        do @(posedge clk); while (!s_tready);
    endtask

    // lowers valid and waits until every expected beat has come
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge clk);
    endtask

    // cycle counter and run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[cpu8_alu_immediate_and_restart] ERROR");
            $finish;
        end
    end

    // queue expectations on input beats, check output beats
    always @(posedge clk)
    begin
        result_beat_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                expected_beats.push_back(offer_lead);
                if (offer_count == 2)
                    expected_beats.push_back(offer_tail);
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_beats.size() == 0)
                    report_mismatch("result beat with nothing expected");
                else
                begin
                    want = expected_beats.pop_front();
                    check_field("acc_out", m_tdata[7:0], want.acc);
                    check_field("flags_out", m_tdata[15:8], want.flags);
                    check_field("pc_out", m_tdata[31:16], want.pc);
                    check_field("sp_out", m_tdata[47:32], want.sp);
                    check_field("write_address", m_tdata[63:48], want.waddr);
                    check_field("write_data", m_tdata[71:64], want.wdata);
                    check_field("cycle_cost", m_tdata[76:72], want.cost);
                    check_field("mem_write", m_tuser, want.mem_write);
                    check_field("last", m_tlast, want.last);
                end
            end
        end
    end

    // receiver: random ready, or a long hold-off when asked
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES - 1) @(negedge clk);
                rx_hold_req = 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // reset, directed table, random instructions, drain
    initial
    begin
        logic [7:0]  opc;
        logic [15:0] pc;
        logic [15:0] sp;
        int          pick;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 12;
        rx_idle_pct = 80;
        foreach (directed_vecs[i])
            offer_instr(directed_vecs[i].opc, directed_vecs[i].imm, directed_vecs[i].a,
                        directed_vecs[i].f, directed_vecs[i].pc, directed_vecs[i].sp,
                        directed_vecs[i].typed, directed_vecs[i].want);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // idling phases: sender light, then receiver light, then none
            if (i == RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 80;
                rx_idle_pct = 12;
            end
            if (i == 2 * RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (i == RANDOM_ITEMS / 2)
                drain_results();
            if (i == 3 * RANDOM_ITEMS / 4)
                rx_hold_req = 1'b1;

            // mostly alu and restart opcodes from any block, some noise
            pick = $urandom_range(99);
            if (pick < 55)
                opc = {2'($urandom_range(3)), 3'($urandom_range(7)), c8alu_pkg::GRP_ALU};
            else if (pick < 80)
                opc = {2'($urandom_range(3)), 3'($urandom_range(7)), c8alu_pkg::GRP_RST};
            else
                opc = 8'($urandom_range(255));
            pc = ($urandom_range(9) == 0) ? 16'hFFFF - 16'($urandom_range(1))
                                          : 16'($urandom_range(65535));
            sp = ($urandom_range(9) == 0) ? 16'($urandom_range(1))
                                          : 16'($urandom_range(65535));
            offer_instr(opc, corner_byte(), corner_byte(), 8'($urandom_range(255)),
                        pc, sp, 1'b0, '0);
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("[cpu8_alu_immediate_and_restart] OK");
        else
            $display("[cpu8_alu_immediate_and_restart] ERROR");
        $finish;
    end

endmodule
